### hw/rtl/bflf_pkg.sv
// Shared types, constants and command/status structs for the bin fill level filter.
// No dependencies.
`default_nettype none
package bflf_pkg;
  localparam int unsigned BINS = 4;
  localparam int unsigned WINDOW = 5;
  localparam int unsigned DW = 13;
  localparam int unsigned PW = 15;
  localparam logic [DW-1:0] OUTLIER_LIMIT = 13'd48;
  localparam logic [PW-1:0] DEADBAND_STEP = 15'd1280;
  localparam logic [31:0] BLANKING_MS = 32'd2000;
  localparam logic [DW:0] REJECT_MARGIN = 14'd320;
  localparam logic [PW-1:0] FULL_SCALE = 15'd25600;
  localparam logic [DW-1:0] EMPTY_RST = 13'd608;
  localparam logic [DW-1:0] FULL_RST = 13'd128;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_DROP = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_HELD = 3'd1;
  localparam logic [2:0] ST_BLANKED = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_LOAD, S_SORT, S_SUM, S_AVG_DIV, S_PCT, S_PCT_DIV, S_COMMIT, S_OUT
  } state_t;

  typedef struct packed {
    logic latch;      // capture input item
    logic decide;     // apply commands / classify sample
    logic load;       // write ring, load sort buffer
    logic sort_step;  // one odd/even transposition pass
    logic sum_step;   // accumulate one entry
    logic div_start;
    logic div_step;
    logic avg_done;   // capture average, set up percent
    logic pct_start;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_sample;  // accepted sample needing the filter
    logic div_done;
    logic pct_direct; // percent needs no division
  } sts_t;
endpackage
`default_nettype wire

### hw/rtl/bin_fill_level_filter_top.sv
// Top level of the bin fill level filter: controller, datapath and output register.
// Depends on bflf_pkg, bflf_ctrl, bflf_dp.
// One item at a time. A drop, clear, spare-mode item or blanked/rejected sample goes
// from the decide state straight to the output register. An accepted sample first passes
// through the odd/even sort passes, the serial sum and a bit-serial division for the
// average, then a second division on the same divider for the percent unless the average
// lands at or beyond the empty or full distance. A new item is taken once the previous
// result has moved into the output register.
`default_nettype none
module bin_fill_level_filter_top (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] in_mode,
  input  wire logic [1:0] in_bin_index,
  input  wire logic [12:0] in_raw_distance,
  input  wire logic [31:0] in_now_ms,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [14:0] out_fill_percent_fine,
  output logic [6:0] out_fill_percent_whole,
  output logic [12:0] out_held_distance,
  output logic [2:0] out_status,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [12:0] cfg_data
);
  bflf_pkg::cmd_t cmd;
  bflf_pkg::sts_t sts;
  logic busy, in_fire, out_free;
  logic [14:0] fine;
  logic [6:0] whole;
  logic [12:0] held_dist;
  logic [2:0] stat;
  logic out_valid_r;

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  bflf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  bflf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_mode(in_mode), .in_bin_index(in_bin_index), .in_raw_distance(in_raw_distance),
    .in_now_ms(in_now_ms), .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .res_fine(fine), .res_whole(whole), .res_dist(held_dist), .res_status(stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_fill_percent_fine <= fine;
      out_fill_percent_whole <= whole;
      out_held_distance <= held_dist;
      out_status <= stat;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

### hw/rtl/bflf_ctrl.sv
// Controller state machine for the bin fill level filter.
// Depends on bflf_pkg.
`default_nettype none
module bflf_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  wire bflf_pkg::sts_t sts,
  output bflf_pkg::cmd_t cmd,
  output logic busy
);
  bflf_pkg::state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bflf_pkg::S_IDLE;
      cnt_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      bflf_pkg::S_IDLE: if (in_fire) state_nxt = bflf_pkg::S_DECIDE;
      bflf_pkg::S_DECIDE: begin
        if (sts.is_sample) state_nxt = bflf_pkg::S_LOAD;
        else state_nxt = bflf_pkg::S_OUT;
      end
      bflf_pkg::S_LOAD: begin
        state_nxt = bflf_pkg::S_SORT;
        cnt_nxt = 3'd0;
      end
      bflf_pkg::S_SORT: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(bflf_pkg::WINDOW - 1)) begin
          state_nxt = bflf_pkg::S_SUM;
          cnt_nxt = 3'd0;
        end
      end
      bflf_pkg::S_SUM: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(bflf_pkg::WINDOW - 1)) begin
          state_nxt = bflf_pkg::S_AVG_DIV;
          cnt_nxt = 3'd0;
        end
      end
      bflf_pkg::S_AVG_DIV: begin
        cnt_nxt = 3'd1;
        if (sts.div_done) state_nxt = bflf_pkg::S_PCT;
      end
      bflf_pkg::S_PCT: begin
        if (sts.pct_direct) state_nxt = bflf_pkg::S_COMMIT;
        else state_nxt = bflf_pkg::S_PCT_DIV;
      end
      bflf_pkg::S_PCT_DIV: if (sts.div_done) state_nxt = bflf_pkg::S_COMMIT;
      bflf_pkg::S_COMMIT: state_nxt = bflf_pkg::S_OUT;
      bflf_pkg::S_OUT: if (out_free) state_nxt = bflf_pkg::S_IDLE;
      default: state_nxt = bflf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != bflf_pkg::S_IDLE);
    case (state_r)
      bflf_pkg::S_IDLE: cmd.latch = in_fire;
      bflf_pkg::S_DECIDE: cmd.decide = 1'b1;
      bflf_pkg::S_LOAD: cmd.load = 1'b1;
      bflf_pkg::S_SORT: cmd.sort_step = 1'b1;
      bflf_pkg::S_SUM: cmd.sum_step = 1'b1;
      bflf_pkg::S_AVG_DIV: begin
        cmd.div_start = (cnt_r == 3'd0);
        cmd.div_step = 1'b1;
        cmd.avg_done = sts.div_done;
      end
      bflf_pkg::S_PCT: cmd.pct_start = 1'b1;
      bflf_pkg::S_PCT_DIV: cmd.div_step = 1'b1;
      bflf_pkg::S_COMMIT: cmd.commit = 1'b1;
      bflf_pkg::S_OUT: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/bflf_div.sv
// Restoring radix-2 divider, one quotient bit per cycle while step is high, 28-bit dividend, 14-bit divisor.
// Depends on no package.
`default_nettype none
module bflf_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic step,
  input  wire logic [27:0] dividend,
  input  wire logic [13:0] divisor,
  output logic [27:0] quotient,
  output logic done
);
  logic [27:0] q_r, q_nxt;
  logic [14:0] rem_r, rem_nxt;
  logic [13:0] dsr_r;
  logic [4:0] cnt_r, cnt_nxt;
  logic [14:0] trial;
  logic [15:0] diff;

  always_comb begin
    trial = {rem_r[13:0], q_r[27]};
    diff = {1'b0, trial} - {2'b00, dsr_r};
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    if (step && cnt_r != 5'd0) begin
      cnt_nxt = cnt_r - 5'd1;
      if (!diff[15]) begin
        rem_nxt = diff[14:0];
        q_nxt = {q_r[26:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[26:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
    end else if (start) begin
      cnt_r <= 5'd28;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = q_r;
  assign done = (cnt_r == 5'd0) && !start;
endmodule
`default_nettype wire

### hw/rtl/bflf_dp.sv
// Datapath: bin state, ring, sort buffer, averaging and percent computation.
// Depends on bflf_pkg and bflf_div.
`default_nettype none
module bflf_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire bflf_pkg::cmd_t cmd,
  output bflf_pkg::sts_t sts,
  input  wire logic [1:0] in_mode,
  input  wire logic [1:0] in_bin_index,
  input  wire logic [12:0] in_raw_distance,
  input  wire logic [31:0] in_now_ms,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [12:0] cfg_data,
  output logic [14:0] res_fine,
  output logic [6:0] res_whole,
  output logic [12:0] res_dist,
  output logic [2:0] res_status
);
  localparam int unsigned W = bflf_pkg::WINDOW;

  logic [12:0] empty_r [bflf_pkg::BINS];
  logic [12:0] full_r [bflf_pkg::BINS];
  logic [12:0] ring_r [bflf_pkg::BINS][W];
  logic [2:0] wpos_r [bflf_pkg::BINS];
  logic [2:0] held_cnt_r [bflf_pkg::BINS];
  logic [31:0] blank_r [bflf_pkg::BINS];
  logic [12:0] havg_r [bflf_pkg::BINS];
  logic [14:0] hpct_r [bflf_pkg::BINS];
  logic first_r [bflf_pkg::BINS];

  logic [1:0] mode_r, bin_r;
  logic [12:0] raw_r;
  logic [31:0] now_r;
  logic [2:0] status_r;
  logic [12:0] tmp_r [W];
  logic [12:0] orig_r [W];
  logic [2:0] n_r;
  logic [2:0] sidx_r;
  logic [15:0] sum_r;
  logic [2:0] used_r;
  logic sort_par_r;
  logic [12:0] avg_r;
  logic [14:0] pct_r;
  logic direct_r;

  logic [12:0] e_cur, f_cur, med;
  logic [12:0] cur_s, dabs;
  logic [27:0] div_a;
  logic [13:0] div_b;
  logic [27:0] div_q;
  logic div_done;
  logic div_start;
  logic [14:0] pdiff;
  logic [15:0] whole_w;

  assign e_cur = empty_r[bin_r];
  assign f_cur = full_r[bin_r];
  assign med = tmp_r[n_r[2:1]];
  assign cur_s = orig_r[sidx_r];
  assign dabs = (cur_s >= med) ? cur_s - med : med - cur_s;

  assign sts.is_sample = (mode_r == bflf_pkg::MODE_SAMPLE) && !(now_r < blank_r[bin_r])
    && raw_r != 13'd0 && ({1'b0, raw_r} <= {1'b0, e_cur} + bflf_pkg::REJECT_MARGIN);
  assign sts.div_done = div_done;
  assign sts.pct_direct = direct_r;

  always_comb begin
    div_a = {12'd0, sum_r};
    div_b = {11'd0, used_r};
    if (cmd.pct_start) begin
      div_a = 28'(({15'd0, e_cur} - {15'd0, avg_r}) * 28'(bflf_pkg::FULL_SCALE));
      div_b = {1'b0, e_cur - f_cur};
    end
  end
  assign div_start = cmd.div_start || (cmd.pct_start && !direct_r);

  bflf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .step(cmd.div_step),
    .dividend(div_a), .divisor(div_b), .quotient(div_q), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < bflf_pkg::BINS; b++) begin
        empty_r[b] <= bflf_pkg::EMPTY_RST;
        full_r[b] <= bflf_pkg::FULL_RST;
        for (int j = 0; j < W; j++) ring_r[b][j] <= bflf_pkg::EMPTY_RST;
        wpos_r[b] <= 3'd0;
        held_cnt_r[b] <= 3'd0;
        blank_r[b] <= 32'd0;
        havg_r[b] <= bflf_pkg::EMPTY_RST;
        hpct_r[b] <= 15'd0;
        first_r[b] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        if (!cfg_idx[2]) begin
          empty_r[cfg_idx[1:0]] <= cfg_data;
          havg_r[cfg_idx[1:0]] <= cfg_data;
        end else begin
          full_r[cfg_idx[1:0]] <= cfg_data;
        end
      end
      if (cmd.decide) begin
        if (mode_r == bflf_pkg::MODE_DROP) begin
          blank_r[bin_r] <= now_r + bflf_pkg::BLANKING_MS;
        end else if (mode_r == bflf_pkg::MODE_CLEAR) begin
          for (int j = 0; j < W; j++) ring_r[bin_r][j] <= e_cur;
          wpos_r[bin_r] <= 3'd0;
          held_cnt_r[bin_r] <= 3'd0;
          blank_r[bin_r] <= 32'd0;
          havg_r[bin_r] <= e_cur;
          hpct_r[bin_r] <= 15'd0;
          first_r[bin_r] <= 1'b0;
        end
      end
      if (cmd.load) begin
        ring_r[bin_r][wpos_r[bin_r]] <= raw_r;
        wpos_r[bin_r] <= (wpos_r[bin_r] == 3'(W - 1)) ? 3'd0 : wpos_r[bin_r] + 3'd1;
        if (held_cnt_r[bin_r] < 3'(W)) held_cnt_r[bin_r] <= held_cnt_r[bin_r] + 3'd1;
      end
      if (cmd.commit && (!first_r[bin_r] || pdiff >= bflf_pkg::DEADBAND_STEP)) begin
        havg_r[bin_r] <= avg_r;
        hpct_r[bin_r] <= pct_r;
        first_r[bin_r] <= 1'b1;
      end
    end
  end

  assign pdiff = (pct_r >= hpct_r[bin_r]) ? pct_r - hpct_r[bin_r] : hpct_r[bin_r] - pct_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      bin_r <= in_bin_index;
      raw_r <= in_raw_distance;
      now_r <= in_now_ms;
    end
    if (cmd.decide) begin
      status_r <= (mode_r != bflf_pkg::MODE_SAMPLE) ? bflf_pkg::ST_DONE
        : (now_r < blank_r[bin_r]) ? bflf_pkg::ST_BLANKED
        : (!sts.is_sample) ? bflf_pkg::ST_REJECTED : bflf_pkg::ST_DONE;
    end
    if (cmd.load) begin
      // entries beyond the filled count sort high and are never summed
      for (int j = 0; j < W; j++) begin
        logic [12:0] v;
        v = (3'(j) == wpos_r[bin_r]) ? raw_r : ring_r[bin_r][j];
        orig_r[j] <= v;
        tmp_r[j] <= (3'(j) < ((held_cnt_r[bin_r] < 3'(W)) ? held_cnt_r[bin_r] + 3'd1
          : held_cnt_r[bin_r])) ? v : 13'h1FFF;
      end
      n_r <= (held_cnt_r[bin_r] < 3'(W)) ? held_cnt_r[bin_r] + 3'd1 : held_cnt_r[bin_r];
      sort_par_r <= 1'b0;
      sidx_r <= 3'd0;
      sum_r <= 16'd0;
      used_r <= 3'd0;
    end
    if (cmd.sort_step) begin
      sort_par_r <= !sort_par_r;
      for (int j = 0; j + 1 < W; j++) begin
        if ((j % 2) == int'(sort_par_r) && tmp_r[j] > tmp_r[j+1]) begin
          tmp_r[j] <= tmp_r[j+1];
          tmp_r[j+1] <= tmp_r[j];
        end
      end
    end
    if (cmd.sum_step) begin
      sidx_r <= sidx_r + 3'd1;
      if (sidx_r < n_r && dabs <= bflf_pkg::OUTLIER_LIMIT) begin
        sum_r <= sum_r + {3'd0, cur_s};
        used_r <= used_r + 3'd1;
      end
    end
    if (cmd.avg_done) begin
      avg_r <= (used_r == 3'd0) ? med : div_q[12:0];
    end
    if (cmd.pct_start) begin
      direct_r <= 1'b0;
      if (avg_r >= e_cur) begin
        pct_r <= 15'd0;
      end else if (avg_r <= f_cur) begin
        pct_r <= bflf_pkg::FULL_SCALE;
      end
    end else if (cmd.avg_done) begin
      direct_r <= (((used_r == 3'd0) ? med : div_q[12:0]) >= e_cur)
        || (((used_r == 3'd0) ? med : div_q[12:0]) <= f_cur);
    end
    if (!direct_r && !cmd.pct_start && cmd.div_step && div_done && !cmd.avg_done) begin
      pct_r <= (div_q > 28'(bflf_pkg::FULL_SCALE)) ? bflf_pkg::FULL_SCALE : div_q[14:0];
    end
    if (cmd.commit) begin
      status_r <= (!first_r[bin_r] || pdiff >= bflf_pkg::DEADBAND_STEP) ?
        bflf_pkg::ST_UPDATED : bflf_pkg::ST_HELD;
    end
  end

  assign res_fine = hpct_r[bin_r];
  assign whole_w = ({1'b0, hpct_r[bin_r]} + 16'd128) >> 8;
  assign res_whole = (whole_w > 16'd100) ? 7'd100 : whole_w[6:0];
  assign res_dist = havg_r[bin_r];
  assign res_status = status_r;
endmodule
`default_nettype wire

### hw/rtl/bflf_checker.sv
// Port-level checker for bin_fill_level_filter_top, bound to the top level.
// Depends on bin_fill_level_filter_top ports only.
`default_nettype none
module bflf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [14:0] out_fill_percent_fine,
  input wire logic [6:0] out_fill_percent_whole,
  input wire logic [2:0] out_status
);
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
  a_fine_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_percent_fine <= 15'd25600) else $error("fine out of range");
  a_whole_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_percent_whole <= 7'd100) else $error("whole out of range");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'd4) else $error("bad status");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)) else $error("output dropped");
endmodule

bind bin_fill_level_filter_top bflf_checker u_bflf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_fill_percent_fine(out_fill_percent_fine),
  .out_fill_percent_whole(out_fill_percent_whole), .out_status(out_status)
);
`default_nettype wire

### tb/sv/bin_fill_level_filter_top_tb.sv
// Testbench for bin_fill_level_filter_top: random and directed items against a
// cycle-free predictor of the four-bin distance filter. Depends on bflf_pkg.
`timescale 1ns / 1ps
module bin_fill_level_filter_top_tb;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  bin;
    logic [12:0] raw;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [14:0] fine;
    logic [6:0]  whole;
    logic [12:0] held;
    logic [2:0]  status;
  } level_t;

  localparam int LIMIT_CYCLES = 600000;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic [1:0] in_mode = 0, in_bin_index = 0;
  logic [12:0] in_raw_distance = 0;
  logic [31:0] in_now_ms = 0;
  logic [2:0] cfg_index = 0;
  logic [12:0] cfg_data = 0;
  logic in_ready, out_valid, cfg_ready;
  logic [14:0] out_fill_percent_fine;
  logic [6:0] out_fill_percent_whole;
  logic [12:0] out_held_distance;
  logic [2:0] out_status;

  bin_fill_level_filter_top DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [12:0] empty_d [bflf_pkg::BINS];
  logic [12:0] full_d [bflf_pkg::BINS];
  logic [12:0] ring [bflf_pkg::BINS][bflf_pkg::WINDOW];
  int unsigned wpos [bflf_pkg::BINS], nheld [bflf_pkg::BINS];
  logic [31:0] blank_end [bflf_pkg::BINS];
  logic [12:0] avg_held [bflf_pkg::BINS];
  logic [14:0] pct_held [bflf_pkg::BINS];
  bit first_done [bflf_pkg::BINS];

  item_t  pending_items[$];
  level_t expected_levels[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  bit stall_long = 0;
  int stall_left = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic void clear_bin(input int b);
    for (int j = 0; j < bflf_pkg::WINDOW; j++) ring[b][j] = empty_d[b];
    wpos[b] = 0; nheld[b] = 0; blank_end[b] = 0;
    avg_held[b] = empty_d[b]; pct_held[b] = 0; first_done[b] = 0;
  endfunction

  function automatic logic [12:0] robust_mean(input int b);
    int unsigned t[bflf_pkg::WINDOW];
    int unsigned n, med, sum, used, key, j, d;
    n = nheld[b]; sum = 0; used = 0;
    if (n < 1) n = 1;
    if (n > bflf_pkg::WINDOW) n = bflf_pkg::WINDOW;
    for (int i = 0; i < n; i++) t[i] = ring[b][i];
    for (int i = 1; i < n; i++) begin
      key = t[i]; j = i;
      while (j > 0 && t[j-1] > key) begin
        t[j] = t[j-1]; j--;
      end
      t[j] = key;
    end
    med = t[n/2];
    for (int i = 0; i < n; i++) begin
      d = (ring[b][i] >= med) ? ring[b][i] - med : med - ring[b][i];
      if (d <= bflf_pkg::OUTLIER_LIMIT) begin
        sum += ring[b][i]; used++;
      end
    end
    return (used == 0) ? 13'(med) : 13'(sum / used);
  endfunction

  function automatic logic [14:0] fill_of(input int b, input int unsigned d);
    int unsigned e, f, p;
    e = empty_d[b]; f = full_d[b];
    if (d >= e) return 15'd0;
    if (d <= f) return bflf_pkg::FULL_SCALE;
    p = (e - d) * bflf_pkg::FULL_SCALE / (e - f);
    return (p > bflf_pkg::FULL_SCALE) ? bflf_pkg::FULL_SCALE : 15'(p);
  endfunction

  function automatic level_t predict_level(input item_t it);
    level_t r;
    int b;
    logic [2:0] st;
    logic [12:0] avg;
    logic [14:0] pct;
    int unsigned diff, whole;
    b = int'(it.bin); st = bflf_pkg::ST_DONE;
    if (it.mode == bflf_pkg::MODE_DROP) begin
      blank_end[b] = it.now + bflf_pkg::BLANKING_MS;
    end else if (it.mode == bflf_pkg::MODE_CLEAR) begin
      clear_bin(b);
    end else if (it.mode == bflf_pkg::MODE_SAMPLE) begin
      if (it.now < blank_end[b]) begin
        st = bflf_pkg::ST_BLANKED;
      end else if (it.raw == 0 || 32'(it.raw) > 32'(empty_d[b]) + 32'(bflf_pkg::REJECT_MARGIN))
      begin
        st = bflf_pkg::ST_REJECTED;
      end else begin
        ring[b][wpos[b]] = it.raw;
        wpos[b] = (wpos[b] + 1) % bflf_pkg::WINDOW;
        if (nheld[b] < bflf_pkg::WINDOW) nheld[b]++;
        avg = robust_mean(b);
        pct = fill_of(b, 32'(avg));
        diff = (pct >= pct_held[b]) ? 32'(pct - pct_held[b]) : 32'(pct_held[b] - pct);
        if (!first_done[b] || diff >= bflf_pkg::DEADBAND_STEP) begin
          avg_held[b] = avg; pct_held[b] = pct; first_done[b] = 1;
          st = bflf_pkg::ST_UPDATED;
        end else begin
          st = bflf_pkg::ST_HELD;
        end
      end
    end
    whole = (32'(pct_held[b]) + 128) >> 8;
    if (whole > 100) whole = 100;
    r.fine = pct_held[b]; r.whole = 7'(whole); r.held = avg_held[b]; r.status = st;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && !(in_valid && !in_ready)) begin
      if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
        item_t it;
        it = pending_items.pop_front();
        expected_levels.push_back(predict_level(it));
        in_valid <= 1;
        in_mode <= it.mode; in_bin_index <= it.bin;
        in_raw_distance <= it.raw; in_now_ms <= it.now;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_long && stall_left == 0) stall_left <= 300;
    else if (stall_left > 0) stall_left <= stall_left - 1;
    out_ready <= rst_n && !(stall_left > 1) && (quiet || $urandom_range(99) >= 7);
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        report("unexpected transfer", 32'(out_status), 32'd0);
      end else begin
        level_t w;
        w = expected_levels.pop_front();
        if (out_fill_percent_fine !== w.fine)
          report("fine", 32'(out_fill_percent_fine), 32'(w.fine));
        if (out_fill_percent_whole !== w.whole)
          report("whole", 32'(out_fill_percent_whole), 32'(w.whole));
        if (out_held_distance !== w.held)
          report("distance", 32'(out_held_distance), 32'(w.held));
        if (out_status !== w.status) report("status", 32'(out_status), 32'(w.status));
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("bin_fill_level_filter_top_tb: FAIL");
      $finish;
    end
  end

  // hold valid between back-to-back writes; release with cfg_release
  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < 4) begin
      empty_d[idx[1:0]] = val; avg_held[idx[1:0]] = val;
    end else begin
      full_d[idx[1:0]] = val;
    end
  endtask

  task automatic cfg_release();
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_levels.size() > 0 || in_valid)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic item_t make_item(input logic [1:0] m, input int b, input logic [12:0] r,
                                      input logic [31:0] t);
    item_t it;
    it.mode = m; it.bin = 2'(b); it.raw = r; it.now = t;
    return it;
  endfunction

  function automatic logic [12:0] near_reading(input int b);
    int unsigned lo, hi;
    lo = full_d[b] > 40 ? 32'(full_d[b]) - 40 : 1;
    hi = 32'(empty_d[b]) + 330;
    if (hi > 8191) hi = 8191;
    if (lo > hi) lo = 1;
    return 13'($urandom_range(hi, lo));
  endfunction

  initial begin
    logic [31:0] t;
    int b, kind;
    logic [12:0] base;
    for (int i = 0; i < bflf_pkg::BINS; i++) begin
      empty_d[i] = bflf_pkg::EMPTY_RST; full_d[i] = bflf_pkg::FULL_RST; clear_bin(i);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    quiet = 1;
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 0, 13'd400, 32'd0));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 0, 13'd0, 32'd5));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 0, 13'd929, 32'd6));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 0, 13'd928, 32'd7));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 1, 13'd8191, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 1, 13'd100, 32'd8));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 1, 13'd128, 32'd9));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 1, 13'd410, 32'd10));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 1, 13'd420, 32'd11));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 1, 13'd900, 32'd12));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 1, 13'd415, 32'd13));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 1, 13'd200, 32'd14));
    pending_items.push_back(make_item(bflf_pkg::MODE_DROP, 2, 13'h1FFF, 32'hFFFF_FC00));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 2, 13'd300, 32'hFFFF_FC01));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 2, 13'd300, 32'd100));
    pending_items.push_back(make_item(bflf_pkg::MODE_DROP, 3, 13'd0, 32'd1000));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 3, 13'd300, 32'd2999));
    pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, 3, 13'd300, 32'd3000));
    pending_items.push_back(make_item(bflf_pkg::MODE_CLEAR, 3, 13'h1555, 32'd3001));
    pending_items.push_back(make_item(MODE_SPARE, 2, 13'h0AAA, 32'h5555_5555));
    pending_items.push_back(make_item(bflf_pkg::MODE_CLEAR, 0, 13'd0, 32'd0));
    drain();

    // extreme settings, including empty not above full
    write_reg(3'd0, 13'd8191); write_reg(3'd4, 13'd0);
    write_reg(3'd1, 13'd100);  write_reg(3'd5, 13'd100);
    write_reg(3'd2, 13'd0);    write_reg(3'd6, 13'd8191);
    write_reg(3'd3, 13'd1000); write_reg(3'd7, 13'd999);
    cfg_release();
    for (int i = 0; i < 24; i++)
      pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, i % 4,
                                        13'($urandom_range(8191, 1)), 32'd0));
    drain();
    quiet = 0;

    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 8; i++) begin
        if (phase == 3)
          write_reg(3'(i), i < 4 ? bflf_pkg::EMPTY_RST : bflf_pkg::FULL_RST);
        else if (i < 4) write_reg(3'(i), 13'($urandom_range(3000, 300)));
        else write_reg(3'(i), 13'($urandom_range(250, 0)));
      end
      cfg_release();
      t = $urandom;
      for (int n = 0; n < 250; n++) begin
        t = t + $urandom_range(400);
        b = $urandom_range(3);
        kind = $urandom_range(99);
        if (kind < 70) begin
          base = near_reading(b);
          pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, b, base, t));
        end else if (kind < 78) begin
          pending_items.push_back(make_item(bflf_pkg::MODE_SAMPLE, b, 13'($urandom),
                                            $urandom));
        end else if (kind < 86) begin
          pending_items.push_back(make_item(bflf_pkg::MODE_DROP, b, 13'($urandom), t));
        end else if (kind < 93) begin
          pending_items.push_back(make_item(bflf_pkg::MODE_CLEAR, b, 13'($urandom),
                                            $urandom));
        end else begin
          pending_items.push_back(make_item(MODE_SPARE, b, 13'($urandom), $urandom));
        end
      end
      if (phase == 1) begin
        stall_long = 1;
        repeat (2) @(posedge clk);
        stall_long = 0;
      end
      if (phase == 2) quiet = 1;
      drain();
      quiet = 0;
    end

    if (errors == 0) $display("bin_fill_level_filter_top_tb: PASS");
    else $display("bin_fill_level_filter_top_tb: FAIL");
    $finish;
  end
endmodule
